// ===== hdl/circular_message_log_store_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the message log store
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_MESSAGE_LOG_STORE_MACROS_SVH
`define CIRCULAR_MESSAGE_LOG_STORE_MACROS_SVH

// Same-cycle implication.
`define CMLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CMLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cmls_pkg.sv =====
// ----------------------------------------------------------------------------
// Message log store package
// Widths, codes, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cmls_pkg;

    localparam int CELL_W          = 10;
    localparam int CELL_COUNT      = 1 << CELL_W;
    localparam int BYTE_W          = 8;
    localparam int FUNC_W          = 3;
    localparam int STORE_DEPTH_DEF = 1024;

    // a begin scan gives up after this many steps
    localparam int SCAN_LIMIT = 1024;
    localparam int CNT_W      = $clog2(SCAN_LIMIT) + 1;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] RING_FIRST_RST = 10'd2;
    localparam logic [CELL_W-1:0] RING_LAST_RST  = 10'd1023;
    localparam logic [CELL_W-1:0] WCUR_RST       = 10'd2;
    localparam logic [CELL_W-1:0] MARK_RST       = 10'd1023;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RING_FIRST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_LAST  = 1'd1;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FWD    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FETCH  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
        logic [CELL_W-1:0] start_cell;
    } item_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
        logic [CELL_W-1:0] write_pos;
        logic [CELL_W-1:0] fwd_mark;
        logic [CELL_W-1:0] back_mark;
    } result_t;

    // controller commands to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_INIT_WR,
        CMD_CLR_FIRST,
        CMD_CLR_STEP,
        CMD_CLR_DONE,
        CMD_APPEND,
        CMD_BEGIN,
        CMD_SCAN_INIT,
        CMD_SCAN_STEP,
        CMD_SCAN2_START,
        CMD_BACK_OK,
        CMD_FWD_OK,
        CMD_FAIL,
        CMD_FETCH,
        CMD_NOP_DONE
    } cmd_op_t;

    // datapath status to the controller
    typedef struct packed {
        logic init_end;
        logic clr_end;
        logic rdata_zero;
        logic start_bad;
        logic scan_end;
        logic slot_free;
    } sts_t;

endpackage

// ===== hdl/cmls_ctrl.sv =====
// ----------------------------------------------------------------------------
// Message log store controller
// Sequences reset clearing, operations and begin scans; issues datapath commands.
// ----------------------------------------------------------------------------
`include "circular_message_log_store_macros.svh"

module cmls_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic [cmls_pkg::FUNC_W-1:0]    item_func,
    input  cmls_pkg::sts_t                 sts,
    output cmls_pkg::cmd_op_t              cmd,
    output logic                           item_stall
);
    import cmls_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CLR0    = 4'd2;
    localparam logic [3:0] S_CLR     = 4'd3;
    localparam logic [3:0] S_APP     = 4'd4;
    localparam logic [3:0] S_FETCH   = 4'd5;
    localparam logic [3:0] S_NOP     = 4'd6;
    localparam logic [3:0] S_B_BEGIN = 4'd7;
    localparam logic [3:0] S_B_CHECK = 4'd8;
    localparam logic [3:0] S_B_SCAN1 = 4'd9;
    localparam logic [3:0] S_B_SCAN2 = 4'd10;
    localparam logic [3:0] S_F_BEGIN = 4'd11;
    localparam logic [3:0] S_F_CHECK = 4'd12;
    localparam logic [3:0] S_F_SCAN  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign item_stall = !((state_reg == S_IDLE) && sts.slot_free);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_INIT:
            begin
                cmd = CMD_INIT_WR;
                if (sts.init_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd = CMD_ACCEPT;
                    case (item_func)
                        FUNC_CLEAR:  state_next = S_CLR0;
                        FUNC_APPEND: state_next = S_APP;
                        FUNC_BACK:   state_next = S_B_BEGIN;
                        FUNC_FWD:    state_next = S_F_BEGIN;
                        FUNC_FETCH:  state_next = S_FETCH;
                        default:     state_next = S_NOP;
                    endcase
                end
            end
            S_CLR0:
            begin
                cmd        = CMD_CLR_FIRST;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                if (sts.clr_end)
                begin
                    cmd        = CMD_CLR_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_CLR_STEP;
                end
            end
            S_APP:
            begin
                cmd        = CMD_APPEND;
                state_next = S_IDLE;
            end
            S_FETCH:
            begin
                cmd        = CMD_FETCH;
                state_next = S_IDLE;
            end
            S_NOP:
            begin
                cmd        = CMD_NOP_DONE;
                state_next = S_IDLE;
            end
            S_B_BEGIN:
            begin
                cmd        = CMD_BEGIN;
                state_next = S_B_CHECK;
            end
            S_F_BEGIN:
            begin
                cmd        = CMD_BEGIN;
                state_next = S_F_CHECK;
            end
            S_B_CHECK, S_F_CHECK:
            begin
                if (sts.start_bad)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SCAN_INIT;
                    state_next = (state_reg == S_B_CHECK) ? S_B_SCAN1 : S_F_SCAN;
                end
            end
            S_B_SCAN1:
            begin
                // looking for the last byte of the previous message
                if (!sts.rdata_zero)
                begin
                    cmd        = CMD_SCAN2_START;
                    state_next = S_B_SCAN2;
                end
                else if (sts.scan_end)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_SCAN_STEP;
                end
            end
            S_B_SCAN2:
            begin
                // looking for the terminator before that message
                if (sts.rdata_zero)
                begin
                    cmd        = CMD_BACK_OK;
                    state_next = S_IDLE;
                end
                else if (sts.scan_end)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_SCAN_STEP;
                end
            end
            S_F_SCAN:
            begin
                if (!sts.rdata_zero)
                begin
                    cmd        = CMD_FWD_OK;
                    state_next = S_IDLE;
                end
                else if (sts.scan_end)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_SCAN_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CMLS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE,
        "accepted transfer did not start work")
    `CMLS_ASSERT_NEXT(a_init_holds, (state_reg == S_INIT) && !sts.init_end,
        state_reg == S_INIT, "reset clearing left early")
    `CMLS_ASSERT_IMP(a_scan_limit_stops,
        (state_reg == S_B_SCAN1 || state_reg == S_B_SCAN2 || state_reg == S_F_SCAN)
        && sts.scan_end,
        cmd == CMD_FAIL || cmd == CMD_FWD_OK || cmd == CMD_BACK_OK || cmd == CMD_SCAN2_START,
        "scan stepped past its limit")

endmodule

// ===== hdl/cmls_dp.sv =====
// ----------------------------------------------------------------------------
// Message log store datapath
// Byte store, cursors, marks, scan pointers and the result register.
// ----------------------------------------------------------------------------
`include "circular_message_log_store_macros.svh"

module cmls_dp #(
    parameter int STORE_DEPTH = cmls_pkg::STORE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmls_pkg::CELL_W-1:0]       cfg_wdata,
    input  cmls_pkg::item_t                   item,
    input  cmls_pkg::cmd_op_t                 cmd,
    output cmls_pkg::sts_t                    sts,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cmls_pkg::result_t                 result
);
    import cmls_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    // conditional subtract steps to fold a cell number into the store
    localparam int RED_STEPS = (STORE_DEPTH >= CELL_COUNT) ? 1
                             : $clog2(CELL_COUNT / STORE_DEPTH) + 1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BACK = 2'd1;
    localparam logic [1:0] MODE_FWD  = 2'd2;

    function automatic logic [AW-1:0] cell_addr(input logic [CELL_W-1:0] cell_no);
        logic [CELL_W-1:0] r;
        r = cell_no;
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (int'(r) >= (STORE_DEPTH << k))
            begin
                r = r - CELL_W'(STORE_DEPTH << k);
            end
        end
        return AW'(r);
    endfunction

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [CELL_W-1:0] ring_first_reg, ring_last_reg;
    logic [CELL_W-1:0] wc_reg, wc_next;
    logic [CELL_W-1:0] fm_reg, fm_next;
    logic [CELL_W-1:0] bm_reg, bm_next;
    logic [CELL_W-1:0] rc_reg, rc_next;
    logic [1:0]        mode_reg, mode_next;
    logic              open_reg, open_next;
    logic [AW-1:0]     init_cnt_reg, init_cnt_next;
    logic              pend_reg, pend_next;
    logic              result_valid_reg, result_valid_next;

    item_t             item_reg, item_next;
    logic [CELL_W-1:0] d_reg, d_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [CELL_W-1:0] ahead_reg, ahead_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              res_status_reg, res_status_next;
    logic [BYTE_W-1:0] res_byte_reg, res_byte_next;
    logic              res_last_reg, res_last_next;
    result_t           result_reg, result_next;

    logic              backward;
    logic [CELL_W-1:0] d_base, d_comb;
    logic [CELL_W-1:0] rd_cell, wr_cell;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic              mem_we, wr_init;
    logic [BYTE_W-1:0] mem_wdata;
    logic              finish;
    logic              slot_free;
    logic              load;

    function automatic logic [CELL_W-1:0] step_fwd(input logic [CELL_W-1:0] c,
                                                   input logic [CELL_W-1:0] rf,
                                                   input logic [CELL_W-1:0] rl);
        return (c == rl) ? rf : c + CELL_W'(1);
    endfunction

    function automatic logic [CELL_W-1:0] step_back(input logic [CELL_W-1:0] c,
                                                    input logic [CELL_W-1:0] rf,
                                                    input logic [CELL_W-1:0] rl);
        return (c == rf) ? rl : c - CELL_W'(1);
    endfunction

    function automatic logic [CELL_W-1:0] step_dir(input logic [CELL_W-1:0] c,
                                                   input logic              back,
                                                   input logic [CELL_W-1:0] rf,
                                                   input logic [CELL_W-1:0] rl);
        return back ? step_back(c, rf, rl) : step_fwd(c, rf, rl);
    endfunction

    assign backward = (item_reg.func == FUNC_BACK);

    // start cell of a retrieval, with the one-outside-the-ring aliases
    always_comb
    begin
        if (backward)
        begin
            d_base = (item_reg.start_cell == '0) ? bm_reg : item_reg.start_cell;
            d_comb = d_base;
            if ((ring_first_reg != '0) && (d_base == ring_first_reg - CELL_W'(1)))
            begin
                d_comb = ring_last_reg;
            end
        end
        else
        begin
            d_base = (item_reg.start_cell == '0) ? fm_reg : item_reg.start_cell;
            d_comb = d_base;
            if ({1'b0, d_base} == ({1'b0, ring_last_reg} + (CELL_W + 1)'(1)))
            begin
                d_comb = ring_first_reg;
            end
        end
    end

    assign slot_free = !result_valid_reg || !result_stall;
    assign load      = pend_reg && slot_free;

    always_comb
    begin
        wc_next         = wc_reg;
        fm_next         = fm_reg;
        bm_next         = bm_reg;
        rc_next         = rc_reg;
        mode_next       = mode_reg;
        open_next       = open_reg;
        init_cnt_next   = init_cnt_reg;
        item_next       = item_reg;
        d_next          = d_reg;
        cur_next        = cur_reg;
        ahead_next      = ahead_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        res_last_next   = res_last_reg;
        finish          = 1'b0;
        mem_we          = 1'b0;
        wr_init         = 1'b0;
        wr_cell         = wc_reg;
        mem_wdata       = CHAR_NUL;
        rd_cell         = rc_reg;
        case (cmd)
            CMD_ACCEPT:
            begin
                item_next = item;
            end
            CMD_INIT_WR:
            begin
                mem_we        = 1'b1;
                wr_init       = 1'b1;
                init_cnt_next = init_cnt_reg + AW'(1);
            end
            CMD_CLR_FIRST:
            begin
                mem_we    = 1'b1;
                wr_cell   = ring_first_reg;
                mem_wdata = CHAR_SPACE;
                cur_next  = ring_first_reg + CELL_W'(1);
            end
            CMD_CLR_STEP:
            begin
                mem_we   = 1'b1;
                wr_cell  = cur_reg;
                cur_next = cur_reg + CELL_W'(1);
            end
            CMD_CLR_DONE:
            begin
                wc_next         = ring_first_reg;
                fm_next         = ring_last_reg;
                bm_next         = ring_last_reg;
                open_next       = 1'b0;
                mode_next       = MODE_IDLE;
                finish          = 1'b1;
                res_status_next = 1'b0;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            CMD_APPEND:
            begin
                // an empty message writes nothing
                if (open_reg || (item_reg.data_byte != CHAR_NUL))
                begin
                    mem_we    = 1'b1;
                    wr_cell   = wc_reg;
                    mem_wdata = item_reg.data_byte;
                    if (item_reg.data_byte == CHAR_NUL)
                    begin
                        fm_next   = wc_reg;
                        bm_next   = wc_reg;
                        open_next = 1'b0;
                    end
                    else
                    begin
                        open_next = 1'b1;
                    end
                    wc_next = step_fwd(wc_reg, ring_first_reg, ring_last_reg);
                end
                finish          = 1'b1;
                res_status_next = 1'b0;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            CMD_BEGIN:
            begin
                rd_cell   = d_comb;
                d_next    = d_comb;
                cur_next  = step_dir(d_comb, backward, ring_first_reg, ring_last_reg);
                mode_next = MODE_IDLE;
            end
            CMD_SCAN_INIT:
            begin
                rd_cell       = cur_reg;
                ahead_next    = step_dir(cur_reg, backward, ring_first_reg, ring_last_reg);
                scan_cnt_next = '0;
            end
            CMD_SCAN_STEP:
            begin
                rd_cell       = ahead_reg;
                cur_next      = ahead_reg;
                ahead_next    = step_dir(ahead_reg, backward, ring_first_reg, ring_last_reg);
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            CMD_SCAN2_START:
            begin
                // second scan starts past the nonzero cell just found and reads the next cell at once
                rd_cell       = ahead_reg;
                cur_next      = ahead_reg;
                ahead_next    = step_dir(ahead_reg, backward, ring_first_reg, ring_last_reg);
                scan_cnt_next = CNT_W'(1);
            end
            CMD_BACK_OK:
            begin
                fm_next         = d_reg;
                bm_next         = cur_reg;
                rc_next         = step_fwd(cur_reg, ring_first_reg, ring_last_reg);
                mode_next       = MODE_BACK;
                finish          = 1'b1;
                res_status_next = 1'b0;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            CMD_FWD_OK:
            begin
                bm_next         = d_reg;
                rc_next         = cur_reg;
                mode_next       = MODE_FWD;
                finish          = 1'b1;
                res_status_next = 1'b0;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            CMD_FAIL:
            begin
                finish          = 1'b1;
                res_status_next = 1'b1;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            CMD_FETCH:
            begin
                finish          = 1'b1;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
                if (mode_reg == MODE_IDLE)
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    res_status_next = 1'b0;
                    res_byte_next   = rdata_reg;
                    if (rdata_reg == CHAR_NUL)
                    begin
                        res_last_next = 1'b1;
                        if (mode_reg == MODE_FWD)
                        begin
                            fm_next = rc_reg;
                        end
                        mode_next = MODE_IDLE;
                    end
                    rc_next = step_fwd(rc_reg, ring_first_reg, ring_last_reg);
                end
            end
            CMD_NOP_DONE:
            begin
                finish          = 1'b1;
                res_status_next = 1'b0;
                res_byte_next   = CHAR_NUL;
                res_last_next   = 1'b0;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    assign mem_raddr = cell_addr(rd_cell);
    assign mem_waddr = wr_init ? init_cnt_reg : cell_addr(wr_cell);

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[mem_raddr];
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (finish)
        begin
            pend_next = 1'b1;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (load)
        begin
            result_next.status    = res_status_reg;
            result_next.read_byte = res_byte_reg;
            result_next.last      = res_last_reg;
            result_next.write_pos = wc_reg;
            result_next.fwd_mark  = fm_reg;
            result_next.back_mark = bm_reg;
            result_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_first_reg   <= RING_FIRST_RST;
            ring_last_reg    <= RING_LAST_RST;
            wc_reg           <= WCUR_RST;
            fm_reg           <= MARK_RST;
            bm_reg           <= MARK_RST;
            rc_reg           <= '0;
            mode_reg         <= MODE_IDLE;
            open_reg         <= 1'b0;
            init_cnt_reg     <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RING_FIRST: ring_first_reg <= cfg_wdata;
                    REG_RING_LAST:  ring_last_reg  <= cfg_wdata;
                    default:        ring_last_reg  <= ring_last_reg;
                endcase
            end
            wc_reg           <= wc_next;
            fm_reg           <= fm_next;
            bm_reg           <= bm_next;
            rc_reg           <= rc_next;
            mode_reg         <= mode_next;
            open_reg         <= open_next;
            init_cnt_reg     <= init_cnt_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        d_reg          <= d_next;
        cur_reg        <= cur_next;
        ahead_reg      <= ahead_next;
        scan_cnt_reg   <= scan_cnt_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_last_reg   <= res_last_next;
        result_reg     <= result_next;
    end

    assign sts.init_end   = (init_cnt_reg == AW'(STORE_DEPTH - 1));
    assign sts.clr_end    = (cur_reg == ring_last_reg + CELL_W'(1));
    assign sts.rdata_zero = (rdata_reg == CHAR_NUL);
    assign sts.start_bad  = (rdata_reg != CHAR_NUL) || (d_reg > ring_last_reg)
                          || (d_reg < ring_first_reg);
    assign sts.scan_end   = (scan_cnt_reg == CNT_W'(SCAN_LIMIT));
    assign sts.slot_free  = !pend_reg || slot_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `CMLS_ASSERT_IMP(a_pend_not_overrun, pend_reg, !finish,
        "result finished while previous one still pending")
    `CMLS_ASSERT_IMP(a_scan_within_limit, cmd == CMD_SCAN_STEP,
        scan_cnt_reg < CNT_W'(SCAN_LIMIT), "scan step beyond limit")
    `CMLS_ASSERT_NEXT(a_clear_sets_cursor, cmd == CMD_CLR_DONE,
        wc_reg == $past(ring_first_reg), "clear did not reload write cursor")

endmodule

// ===== hdl/circular_message_log_store.sv =====
// ----------------------------------------------------------------------------
// Circular message log store
// Byte ring of zero-terminated messages with append and retrieval.
// ----------------------------------------------------------------------------
// Usage notes:
//  - item channel (item_valid / item_stall / item) carries one operation per
//    transfer: clear, append byte, begin backward, begin forward, fetch next.
//  - result channel (result_valid / result_stall / result) returns exactly one
//    result per operation, in order, from an output register.
//  - cfg_we / cfg_index / cfg_wdata write ring_first (index 0) and ring_last
//    (index 1); write only while no operation is outstanding.
//  - Append, fetch and unused codes: each runs in its own controller state,
//    then the controller returns to idle to take the next operation (fetch
//    needs one registered read).
//  - Clear: ring_first to ring_last, one cell written per cycle.
//  - Begin retrieval: the scan walks up to 2 x 1024 cells backward and
//    1024 forward.
//  - After reset the store is zeroed over its STORE_DEPTH cells; item_stall stays
//    high meanwhile. Configuration writes are taken at all times.
//  - A stalled result holds; the next operation is still taken while a result
//    waits, and its own result waits until the register frees up.
// ----------------------------------------------------------------------------
module circular_message_log_store #(
    parameter int STORE_DEPTH = cmls_pkg::STORE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmls_pkg::CELL_W-1:0]       cfg_wdata,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  cmls_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cmls_pkg::result_t                 result
);
    import cmls_pkg::*;

    // controller/datapath handshake
    cmd_op_t cmd;
    sts_t    sts;

    cmls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_func  (item.func),
        .sts        (sts),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    // store, cursors, marks and the result register
    cmls_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
